// File: rtl/skl_pkg.sv
// ----------------------------------------------------------------------------
// Skyline sweep package
// Shared width X_W, entry, point and command types, and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package skl_pkg;

    localparam int X_W = 31;

    typedef struct packed {
        logic [X_W-1:0] height;
        logic [X_W-1:0] right;
    } t_entry;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] height;
    } t_point;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_entry key;
    } t_heap_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_POP,
        S_PUSH,
        S_FIN,
        S_READ,
        S_LOAD
    } t_state;

endpackage

`default_nettype wire

// File: rtl/skl_if.sv
// ----------------------------------------------------------------------------
// Skyline sweep channels
// Building input channel and key point output channel, valid/ready words.
// ----------------------------------------------------------------------------
`default_nettype none

interface skl_in_if;
    import skl_pkg::*;

    logic           valid;
    logic           ready;
    logic [X_W-1:0] left_edge;
    logic [X_W-1:0] right_edge;
    logic [X_W-1:0] bldg_height;
    logic           final_bldg;

    modport source (
        output valid, left_edge, right_edge, bldg_height, final_bldg,
        input  ready
    );

    modport sink (
        input  valid, left_edge, right_edge, bldg_height, final_bldg,
        output ready
    );
endinterface

interface skl_out_if;
    import skl_pkg::*;

    logic           valid;
    logic           ready;
    logic [X_W-1:0] point_x;
    logic [X_W-1:0] point_height;
    logic           point_last;
    logic           overflow;

    modport source (
        output valid, point_x, point_height, point_last, overflow,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_height, point_last, overflow,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/skl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 34
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/skl_cell.sv
// ----------------------------------------------------------------------------
// Skyline sweep heap cell
// One slot of the sorted chain: keeps, takes the new key, or takes a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  wire logic               i_clk,
    input  wire skl_pkg::t_heap_cmd i_cmd,
    input  wire logic [CW-1:0]      i_count,
    input  wire skl_pkg::t_entry    i_left_entry,
    input  wire logic               i_left_keep,
    input  wire skl_pkg::t_entry    i_right_entry,
    output skl_pkg::t_entry         o_entry,
    output logic                    o_keep
);
    import skl_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_valid;

    always_comb begin
        w_valid = IDX_C < i_count;
        o_keep  = w_valid && !(i_cmd.key > r_entry);
        n_entry = r_entry;
        if (i_cmd.push) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_cmd.key : i_left_entry;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: rtl/skl_heap.sv
// ----------------------------------------------------------------------------
// Skyline sweep active set
// Chain of cells sorted by height, then right edge, with the top in cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_heap #(
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire skl_pkg::t_heap_cmd         i_cmd,
    output skl_pkg::t_entry                 o_top,
    output logic [$clog2(DEPTH+1)-1:0]      o_count,
    output logic                            o_full
);
    import skl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_entry          w_entry [DEPTH];
    logic            w_keep  [DEPTH];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_lkeep;

        if (i == 0) begin : g_first
            assign w_left  = '0;
            assign w_lkeep = 1'b1;
        end else begin : g_mid
            assign w_left  = w_entry[i-1];
            assign w_lkeep = w_keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[i+1];
        end

        skl_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (i_cmd),
            .i_count       (r_count),
            .i_left_entry  (w_left),
            .i_left_keep   (w_lkeep),
            .i_right_entry (w_right),
            .o_entry       (w_entry[i]),
            .o_keep        (w_keep[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push && !o_full) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop && r_count != '0) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = w_entry[0];
    assign o_count = r_count;
    assign o_full  = r_count == CW'(DEPTH);

endmodule

`default_nettype wire

// File: rtl/skyline_sweep_heap.sv
// ----------------------------------------------------------------------------
// Skyline sweep over a sorted active set
// Turns buildings sorted by left edge into skyline key points.
// ----------------------------------------------------------------------------
// Buildings arrive on i_bldg, one word each, sorted by left edge; the word
// with final_bldg set closes the set and drains the active buildings. Key
// points leave on o_point; point_last marks the last point of a set, and
// overflow is a sticky flag for a dropped building or a point limit hit.
// One building is worked at a time: the word is taken and checked against
// the open group of its left edge. A new left edge scans the active set,
// and each group of removed buildings is popped in a loop. Then come the
// insert and the close; a final word scans and removes again in the same
// way, and the result RAM is read back point by point, or skipped when
// there is none. A building that joins the open group skips the scan; the
// worst case grows with HEAP_DEPTH through the removal loop.
// The active set is a chain of HEAP_DEPTH cells that inserts or removes one
// building per cycle. Points are collected in a RAM of HEAP_DEPTH+2 words
// before any is sent, since the overflow flag they carry is settled only
// at the end of the building.
// Reset clears the active set, the state and the overflow and valid flags.
// When the receiver stalls, the output register holds its word and the
// read-back waits; the next building is taken while the last point waits.
// ----------------------------------------------------------------------------
`default_nettype none

module skyline_sweep_heap #(
    parameter int HEAP_DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    skl_in_if.sink     i_bldg,
    skl_out_if.source  o_point
);
    import skl_pkg::*;

    localparam int CW      = $clog2(HEAP_DEPTH + 1);
    localparam int MAX_RES = HEAP_DEPTH + 2;
    localparam int AW      = $clog2(MAX_RES);
    localparam int OCW     = $clog2(MAX_RES + 1);

    t_state         r_state, n_state;
    logic [X_W-1:0] r_left, n_left;
    logic [X_W-1:0] r_right, n_right;
    logic [X_W-1:0] r_height, n_height;
    logic           r_fin, n_fin;
    logic [X_W-1:0] r_pend_x, n_pend_x;
    logic           r_pend_v, n_pend_v;
    logic [X_W-1:0] r_prev_h, n_prev_h;
    logic           r_any, n_any;
    logic           r_ovf, n_ovf;
    logic           r_drain, n_drain;
    logic [X_W-1:0] r_cp, n_cp;
    logic [OCW-1:0] r_ocount, n_ocount;
    logic [OCW-1:0] r_rd_idx, n_rd_idx;
    logic           r_out_valid, n_out_valid;
    t_point         r_out, n_out;
    logic           r_out_last, n_out_last;
    logic           r_out_ovf, n_out_ovf;

    t_heap_cmd      w_cmd;
    t_entry         w_top;
    logic [CW-1:0]  w_count;
    logic           w_full;
    logic           w_cnt_nz;
    logic [X_W-1:0] w_top_h;

    logic           w_emit_req;
    logic [X_W-1:0] w_emit_x;
    logic [X_W-1:0] w_emit_h;
    logic           w_wr_en;
    logic [OCW-1:0] w_slot;
    t_point         w_wr_data;
    logic           w_rd_en;
    t_point         w_rd_data;
    logic [OCW-1:0] w_last_idx;

    skl_heap #(
        .DEPTH (HEAP_DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_top   (w_top),
        .o_count (w_count),
        .o_full  (w_full)
    );

    skl_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_RES)
    ) u_res_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_cnt_nz   = w_count != '0;
    assign w_top_h    = w_cnt_nz ? w_top.height : '0;
    assign w_last_idx = r_ocount - OCW'(1);

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_right     = r_right;
        n_height    = r_height;
        n_fin       = r_fin;
        n_pend_x    = r_pend_x;
        n_pend_v    = r_pend_v;
        n_prev_h    = r_prev_h;
        n_any       = r_any;
        n_ovf       = r_ovf;
        n_drain     = r_drain;
        n_cp        = r_cp;
        n_ocount    = r_ocount;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && !o_point.ready;
        w_cmd       = '0;
        w_cmd.key   = '{height: r_height, right: r_right};
        w_emit_req  = 1'b0;
        w_emit_x    = r_pend_x;
        w_emit_h    = w_top_h;
        w_rd_en     = 1'b0;
        i_bldg.ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_bldg.ready = 1'b1;
                if (i_bldg.valid) begin
                    n_left   = i_bldg.left_edge;
                    n_right  = i_bldg.right_edge;
                    n_height = i_bldg.bldg_height;
                    n_fin    = i_bldg.final_bldg;
                    n_ocount = '0;
                    n_rd_idx = '0;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (r_pend_v && r_left == r_pend_x) begin
                    n_state = S_PUSH;
                end else begin
                    w_emit_req = r_pend_v;
                    n_pend_x   = r_left;
                    n_pend_v   = 1'b1;
                    n_drain    = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_cnt_nz && (r_drain || w_top.right < r_left)) begin
                    n_cp    = w_top.right;
                    n_state = S_POP;
                end else if (r_drain) begin
                    w_cmd.clear = 1'b1;
                    n_pend_x    = '0;
                    n_pend_v    = 1'b0;
                    n_prev_h    = '0;
                    n_any       = 1'b0;
                    n_state     = S_READ;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_POP: begin
                if (w_cnt_nz && w_top.right <= r_cp) begin
                    w_cmd.pop = 1'b1;
                end else begin
                    w_emit_req = 1'b1;
                    w_emit_x   = r_cp;
                    n_state    = S_SCAN;
                end
            end
            S_PUSH: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    w_cmd.push = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_fin) begin
                    w_emit_req = 1'b1;
                    n_drain    = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_ocount == '0) begin
                    n_state = S_IDLE;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || o_point.ready) begin
                    n_out       = w_rd_data;
                    n_out_last  = r_fin && r_rd_idx == w_last_idx;
                    n_out_ovf   = r_ovf;
                    n_out_valid = 1'b1;
                    n_rd_idx    = r_rd_idx + OCW'(1);
                    n_state     = (r_rd_idx == w_last_idx) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A point is kept only when the height changes; past the RAM depth
        // the newest point replaces the last stored one.
        w_wr_en   = w_emit_req && !(r_any && w_emit_h == r_prev_h);
        w_slot    = (r_ocount < OCW'(MAX_RES)) ? r_ocount : w_last_idx;
        w_wr_data = '{x: w_emit_x, height: w_emit_h};
        if (w_wr_en) begin
            n_any    = 1'b1;
            n_prev_h = w_emit_h;
            if (r_ocount < OCW'(MAX_RES)) begin
                n_ocount = r_ocount + OCW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_x    <= '0;
            r_pend_v    <= 1'b0;
            r_prev_h    <= '0;
            r_any       <= 1'b0;
            r_ovf       <= 1'b0;
            r_drain     <= 1'b0;
            r_ocount    <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_x    <= n_pend_x;
            r_pend_v    <= n_pend_v;
            r_prev_h    <= n_prev_h;
            r_any       <= n_any;
            r_ovf       <= n_ovf;
            r_drain     <= n_drain;
            r_ocount    <= n_ocount;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_right    <= n_right;
        r_height   <= n_height;
        r_fin      <= n_fin;
        r_cp       <= n_cp;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_point.valid        = r_out_valid;
    assign o_point.point_x      = r_out.x;
    assign o_point.point_height = r_out.height;
    assign o_point.point_last   = r_out_last;
    assign o_point.overflow     = r_out_ovf;

endmodule

`default_nettype wire

// File: rtl/skl_check.sv
// ----------------------------------------------------------------------------
// Skyline sweep port checker
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_check (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [skl_pkg::X_W-1:0] i_point_x,
    input wire logic [skl_pkg::X_W-1:0] i_point_height,
    input wire logic                    i_point_last,
    input wire logic                    i_overflow
);
    import skl_pkg::*;

    logic r_ovf_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_overflow) begin
            r_ovf_seen <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_point_x)
            && $stable(i_point_height) && $stable(i_point_last)
            && $stable(i_overflow))
        else $error("output word changed while stalled");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_ovf_seen |-> i_overflow)
        else $error("overflow flag cleared after it was reported");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

endmodule

bind skyline_sweep_heap skl_check u_skl_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_point.valid),
    .i_out_ready    (o_point.ready),
    .i_point_x      (o_point.point_x),
    .i_point_height (o_point.point_height),
    .i_point_last   (o_point.point_last),
    .i_overflow     (o_point.overflow)
);

`default_nettype wire
